// ----- rtl/core/vcg_pkg.sv -----
// Package for the disk geometry block: widths, limits, reciprocal constants and the
// pipeline advance struct. It depends on nothing and is used by every module of the block.
package vcg_pkg;

    // Width of the clamped sector count, of the trial quotients and of the final quotient.
    localparam int TOT_W = 28;
    localparam int QUO_W = 24;
    localparam int CTH_W = 20;
    localparam int HD_EST_W = QUO_W + 1 - 10;

    localparam logic [31:0] MAX_SECTORS   = 32'(65535 * 16 * 255);
    localparam logic [TOT_W-1:0] LARGE_SECTORS = TOT_W'(65535 * 16 * 63);

    localparam int TRACK_LIMIT = 1024;

    localparam logic [4:0] HEADS_MIN = 5'd4;
    localparam logic [4:0] HEADS_MAX = 5'd16;

    // Sectors-per-track codes.
    localparam logic [7:0] SPT_17  = 8'd17;
    localparam logic [7:0] SPT_31  = 8'd31;
    localparam logic [7:0] SPT_63  = 8'd63;
    localparam logic [7:0] SPT_255 = 8'd255;

    // floor(2^32 / d): the product estimate is at most one below the true quotient.
    localparam logic [31:0] RECIP_17  = 32'((64'd1 << 32) / 64'd17);
    localparam logic [31:0] RECIP_31  = 32'((64'd1 << 32) / 64'd31);
    localparam logic [31:0] RECIP_63  = 32'((64'd1 << 32) / 64'd63);
    localparam logic [31:0] RECIP_255 = 32'((64'd1 << 32) / 64'd255);

    localparam int RECIP_SHIFT = 32;

    // ceil(2^20 / heads) for heads 4 to 15; exact for dividends below 16384.
    localparam int HD_RECIP_W = 19;
    localparam int HD_SHIFT   = 20;
    localparam int CYL_SMALL_W = 14;

    typedef struct packed {
        logic ld2;
        logic ld3;
    } t_vcg_adv;

    function automatic logic [HD_RECIP_W-1:0] vcg_recip_hd(input logic [4:0] hd);
        logic [HD_RECIP_W-1:0] res;
        case (hd)
            5'd4:    res = 19'd262144;
            5'd5:    res = 19'd209716;
            5'd6:    res = 19'd174763;
            5'd7:    res = 19'd149797;
            5'd8:    res = 19'd131072;
            5'd9:    res = 19'd116509;
            5'd10:   res = 19'd104858;
            5'd11:   res = 19'd95326;
            5'd12:   res = 19'd87382;
            5'd13:   res = 19'd80660;
            5'd14:   res = 19'd74899;
            5'd15:   res = 19'd69906;
            default: res = 19'd65536;
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/core/vcg_quot.sv -----
// Two-stage constant divider: sector count divided by 17, 31, 63 and 255 in parallel.
// Depends on vcg_pkg for widths and reciprocal constants.
module vcg_quot (
    input  logic                      i_clk,
    input  vcg_pkg::t_vcg_adv         i_adv,
    input  logic [vcg_pkg::TOT_W-1:0] i_total,
    output logic [vcg_pkg::QUO_W-1:0] o_q17,
    output logic [vcg_pkg::QUO_W-1:0] o_q31,
    output logic [vcg_pkg::QUO_W-1:0] o_q63,
    output logic [vcg_pkg::QUO_W-1:0] o_q255
);
    import vcg_pkg::*;

    localparam int PROD_W = TOT_W + 32;

    logic [PROD_W-1:0] w_p17, w_p31, w_p63, w_p255;
    logic [TOT_W-1:0]  r_tot;
    logic [QUO_W-1:0]  r_est17, r_est31, r_est63, r_est255;
    logic [QUO_W-1:0]  r_q17, r_q31, r_q63, r_q255;

    // Raise the estimate by one when the remainder still holds a whole divisor.
    function automatic logic [QUO_W-1:0] fix_quot(input logic [QUO_W-1:0] est,
                                                  input logic [TOT_W-1:0] tot,
                                                  input logic [7:0] d);
        logic [TOT_W-1:0] rem;
        rem = tot - TOT_W'(TOT_W'(est) * TOT_W'(d));
        if (rem >= TOT_W'(d)) begin
            return est + QUO_W'(1);
        end
        return est;
    endfunction

    assign w_p17  = PROD_W'(i_total) * PROD_W'(RECIP_17);
    assign w_p31  = PROD_W'(i_total) * PROD_W'(RECIP_31);
    assign w_p63  = PROD_W'(i_total) * PROD_W'(RECIP_63);
    assign w_p255 = PROD_W'(i_total) * PROD_W'(RECIP_255);

    always_ff @(posedge i_clk) begin
        if (i_adv.ld2) begin
            r_tot    <= i_total;
            r_est17  <= w_p17[RECIP_SHIFT +: QUO_W];
            r_est31  <= w_p31[RECIP_SHIFT +: QUO_W];
            r_est63  <= w_p63[RECIP_SHIFT +: QUO_W];
            r_est255 <= w_p255[RECIP_SHIFT +: QUO_W];
        end
        if (i_adv.ld3) begin
            r_q17  <= fix_quot(r_est17, r_tot, SPT_17);
            r_q31  <= fix_quot(r_est31, r_tot, SPT_31);
            r_q63  <= fix_quot(r_est63, r_tot, SPT_63);
            r_q255 <= fix_quot(r_est255, r_tot, SPT_255);
        end
    end

    assign o_q17  = r_q17;
    assign o_q31  = r_q31;
    assign o_q63  = r_q63;
    assign o_q255 = r_q255;

endmodule

// ----- rtl/core/vhd_chs_geometry.sv -----
// Top level of the disk geometry block: clamp, selection and head division stages.
// Depends on vcg_pkg and instantiates vcg_quot for the constant divisions.

// The block turns a disk size in 512-byte sectors into a cylinder, head and
// sectors-per-track geometry. One transaction is accepted per clock cycle while o_stall
// is low, and each gives exactly one result transaction after passing the
// five register stages: clamp, reciprocal multiply, quotient correction, geometry
// selection and division of the quotient by the head count. Every stage holds a valid
// bit, and a stage takes new data whenever it is empty or the stage after it moves, so
// a stalled result does not hold up input while the pipeline has empty stages. Sizes
// above 65535*16*255 sectors are treated as that maximum. There is no configuration
// and nothing is kept from one transaction to the next.
module vhd_chs_geometry (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_total_sectors,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_cylinders,
    output logic [4:0]  o_heads,
    output logic [7:0]  o_sectors_per_track
);
    import vcg_pkg::*;

    // Valid bit of each stage and the load condition of each stage.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    // Stage one: clamped count and large-disk flag.
    logic [TOT_W-1:0] w_clamped;
    logic [TOT_W-1:0] r1_tot;
    logic             r1_large, r2_large, r3_large;

    // Stage three outputs from the divider.
    logic [QUO_W-1:0] w_q17, w_q31, w_q63, w_q255;
    t_vcg_adv         w_adv;

    // Stage four: chosen geometry and cylinder-times-heads quotient.
    logic [QUO_W:0]      w_hsum;
    logic [HD_EST_W-1:0] w_hd_est, w_hd_min;
    logic                w_fail17, w_fit31;
    logic [7:0]          n4_spt, r4_spt;
    logic [4:0]          n4_hd, r4_hd;
    logic [CTH_W-1:0]    n4_cth, r4_cth;

    // Stage five: cylinders.
    logic [CYL_SMALL_W+HD_RECIP_W-1:0] w_cyl_prod;
    logic [15:0]                       n5_cyl, r5_cyl;
    logic [4:0]                        r5_hd;
    logic [7:0]                        r5_spt;

    // A stage loads when it is empty or its contents move on in the same cycle.
    assign w_rdy5 = !r_v5 || !i_stall;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_stall = !w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
            if (w_rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    // Counts above the maximum are pinned to it, so the clamped value fits 28 bits.
    assign w_clamped = (i_total_sectors > MAX_SECTORS) ? TOT_W'(MAX_SECTORS)
                                                       : i_total_sectors[TOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_tot   <= w_clamped;
            r1_large <= (w_clamped >= LARGE_SECTORS);
        end
        if (w_rdy2) begin
            r2_large <= r1_large;
        end
        if (w_rdy3) begin
            r3_large <= r2_large;
        end
    end

    assign w_adv.ld2 = w_rdy2;
    assign w_adv.ld3 = w_rdy3;

    vcg_quot u_quot (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_total (r1_tot),
        .o_q17   (w_q17),
        .o_q31   (w_q31),
        .o_q63   (w_q63),
        .o_q255  (w_q255)
    );

    // The head estimate for 17 sectors per track is the quotient over 1024, rounded up,
    // kept at full width and raised to at least four heads. That geometry is rejected
    // when the quotient does not fit below heads times 1024 or the estimate exceeds 16.
    assign w_hsum   = {1'b0, w_q17} + (QUO_W+1)'(TRACK_LIMIT - 1);
    assign w_hd_est = w_hsum[QUO_W:10];
    assign w_hd_min = (w_hd_est < HD_EST_W'(HEADS_MIN)) ? HD_EST_W'(HEADS_MIN) : w_hd_est;
    assign w_fail17 = ({1'b0, w_q17} >= {w_hd_min, 10'b0}) ||
                      (w_hd_min > HD_EST_W'(HEADS_MAX));
    assign w_fit31  = (w_q31 < QUO_W'(TRACK_LIMIT * 16));

    // Every accepted quotient is below 2^20: the small geometries keep it under 16384,
    // and the 63 and 255 cases are bounded by the two sector limits.
    always_comb begin
        if (r3_large) begin
            n4_spt = SPT_255;
            n4_hd  = HEADS_MAX;
            n4_cth = w_q255[CTH_W-1:0];
        end else if (!w_fail17) begin
            n4_spt = SPT_17;
            n4_hd  = w_hd_min[4:0];
            n4_cth = w_q17[CTH_W-1:0];
        end else if (w_fit31) begin
            n4_spt = SPT_31;
            n4_hd  = HEADS_MAX;
            n4_cth = w_q31[CTH_W-1:0];
        end else begin
            n4_spt = SPT_63;
            n4_hd  = HEADS_MAX;
            n4_cth = w_q63[CTH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r4_spt <= n4_spt;
            r4_hd  <= n4_hd;
            r4_cth <= n4_cth;
        end
    end

    // Sixteen heads is a plain shift. Fewer heads only occur with a quotient below 16384,
    // where a rounded-up reciprocal of the head count gives the exact quotient.
    assign w_cyl_prod = (CYL_SMALL_W+HD_RECIP_W)'(r4_cth[CYL_SMALL_W-1:0]) *
                        (CYL_SMALL_W+HD_RECIP_W)'(vcg_recip_hd(r4_hd));

    always_comb begin
        if (r4_hd == HEADS_MAX) begin
            n5_cyl = r4_cth[CTH_W-1:4];
        end else begin
            n5_cyl = 16'(w_cyl_prod[CYL_SMALL_W+HD_RECIP_W-1:HD_SHIFT]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r5_cyl <= n5_cyl;
            r5_hd  <= r4_hd;
            r5_spt <= r4_spt;
        end
    end

    assign o_valid             = r_v5;
    assign o_cylinders         = r5_cyl;
    assign o_heads             = r5_hd;
    assign o_sectors_per_track = r5_spt;

    // Only the 17 sectors-per-track geometry uses a head count other than sixteen.
    a_heads_sixteen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_sectors_per_track != SPT_17)) |-> (o_heads == HEADS_MAX))
        else $error("geometry with more than 17 sectors per track has fewer than 16 heads");

    // A small geometry must have four to sixteen heads and fewer than 1024 cylinders.
    a_small_geom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_sectors_per_track == SPT_17)) |->
        ((o_heads >= HEADS_MIN) && (o_heads <= HEADS_MAX) && (o_cylinders < 16'd1024)))
        else $error("17 sectors-per-track geometry out of range");

    // A result held by the receiver must still be there in the next cycle.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_cylinders) && $stable(o_heads)))
        else $error("stalled result lost or changed");

    // An output stall towards the sender implies every stage holds a transaction.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && i_stall))
        else $error("input stalled while the pipeline has an empty stage");

endmodule

// ----- bench/tb_vhd_chs_geometry.sv -----
// Self-checking testbench for vhd_chs_geometry: directed and random sector counts.
// It depends only on the RTL of the block (vhd_chs_geometry and vcg_pkg).
// The expected geometry is computed by a local predictor and checked in order.

module tb_vhd_chs_geometry;

    timeunit 1ns;
    timeprecision 1ps;

    // Geometry limits of the disk format, written out independently of the RTL package.
    localparam logic [31:0] SECTORS_CLAMP = 32'd267382800;  // 65535 * 16 * 255
    localparam logic [31:0] SECTORS_WIDE  = 32'd66059280;   // 65535 * 16 * 63
    localparam logic [31:0] TRACK_CYLS    = 32'd1024;
    localparam logic [31:0] HEADS_FLOOR   = 32'd4;
    localparam logic [31:0] HEADS_CEIL    = 32'd16;

    // Sectors-per-track choices: 17, 31 and 63 are tried in this order, 255 is for large disks.
    localparam logic [31:0] SPT_SMALLEST = 32'd17;
    localparam logic [31:0] SPT_MIDDLE   = 32'd31;
    localparam logic [31:0] SPT_REGULAR  = 32'd63;
    localparam logic [31:0] SPT_WIDE     = 32'd255;

    // Handshake pressure phases.
    localparam int PH_FREE     = 0;
    localparam int PH_SEND_GAP = 1;
    localparam int PH_RECV_GAP = 2;
    localparam int PH_BOTH_GAP = 3;

    localparam int RANDOM_ITEMS  = 1900;
    localparam int PHASE_LEN     = 150;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int TAIL_CYCLES   = 20;

    typedef struct packed {
        logic [15:0] cylinders;
        logic [4:0]  heads;
        logic [7:0]  sectors_per_track;
    } t_chs;

    // One pending input transaction: the sector count, the pressure phase in force
    // while it is offered, and whether the sender must first wait for the pipeline
    // to empty completely.
    typedef struct {
        logic [31:0] count;
        int          phase;
        bit          drain;
    } t_disk_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_total_sectors = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_cylinders;
    logic [4:0]  o_heads;
    logic [7:0]  o_sectors_per_track;

    t_disk_item  pending_disks[$];
    t_chs        expected_geom[$];
    int          mismatch_cnt = 0;
    int          cur_phase = PH_FREE;
    bit          disk_taken = 1'b0;
    bit          rst_done = 1'b0;
    int          quiet_cycles = 0;

    vhd_chs_geometry u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_total_sectors     (i_total_sectors),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_cylinders         (o_cylinders),
        .o_heads             (o_heads),
        .o_sectors_per_track (o_sectors_per_track)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Works out the geometry for one sector count. The count is clamped first; large
    // disks take 255 sectors and 16 heads, and smaller ones try 17, then 31, then 63
    // sectors per track. The head estimate is kept at the full 32-bit width, so an
    // estimate above sixteen always moves the search on to 31 sectors.
    function automatic t_chs chs_from_count(input logic [31:0] count);
        logic [31:0] total;
        logic [31:0] spt;
        logic [31:0] hd;
        logic [31:0] cth;
        t_chs        geom;
        total = (count > SECTORS_CLAMP) ? SECTORS_CLAMP : count;
        if (total >= SECTORS_WIDE) begin
            spt = SPT_WIDE;
            hd  = HEADS_CEIL;
            cth = total / spt;
        end else begin
            spt = SPT_SMALLEST;
            cth = total / spt;
            hd  = (cth + TRACK_CYLS - 32'd1) / TRACK_CYLS;
            if (hd < HEADS_FLOOR) begin
                hd = HEADS_FLOOR;
            end
            if (cth >= hd * TRACK_CYLS || hd > HEADS_CEIL) begin
                spt = SPT_MIDDLE;
                hd  = HEADS_CEIL;
                cth = total / spt;
            end
            if (cth >= hd * TRACK_CYLS) begin
                spt = SPT_REGULAR;
                hd  = HEADS_CEIL;
                cth = total / spt;
            end
        end
        geom.cylinders         = 16'(cth / hd);
        geom.heads             = 5'(hd);
        geom.sectors_per_track = 8'(spt);
        return geom;
    endfunction

    // Draws a random sector count. Most draws fall in the ranges where the search
    // stops at 17, 31 or 63 sectors, some land on the edges of the head estimate,
    // and the rest cover the large range, the clamp and the whole 32-bit space.
    function automatic logic [31:0] random_count();
        int          pick;
        logic [31:0] spt_sel;
        logic [31:0] base;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            return $urandom_range(0, 278527);
        end else if (pick < 45) begin
            return $urandom_range(278528, 507903);
        end else if (pick < 60) begin
            return $urandom_range(507904, SECTORS_WIDE - 1);
        end else if (pick < 72) begin
            return $urandom_range(SECTORS_WIDE, SECTORS_CLAMP);
        end else if (pick < 85) begin
            return $urandom();
        end else begin
            case ($urandom_range(0, 2))
                0:       spt_sel = SPT_SMALLEST;
                1:       spt_sel = SPT_MIDDLE;
                default: spt_sel = SPT_REGULAR;
            endcase
            base = 32'($urandom_range(1, 64)) * TRACK_CYLS * spt_sel;
            return base + 32'($urandom_range(0, 2 * spt_sel)) - spt_sel;
        end
    endfunction

    function automatic int send_gap_pct(input int phase);
        case (phase)
            PH_SEND_GAP: return 46;
            PH_BOTH_GAP: return 7;
            default:     return 0;
        endcase
    endfunction

    function automatic int recv_gap_pct(input int phase);
        case (phase)
            PH_RECV_GAP: return 46;
            PH_BOTH_GAP: return 7;
            default:     return 0;
        endcase
    endfunction

    // Prints one line about a mismatch and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic queue_disk(input logic [31:0] count, input int phase, input bit drain);
        t_disk_item item;
        item.count = count;
        item.phase = phase;
        item.drain = drain;
        pending_disks.push_back(item);
    endtask

    // Reset is held from the start, released on a falling edge and never asserted again.
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;
    end

    // Stimulus and the end of the run. The directed part covers the empty disk, the
    // clamp, the boundary into the large range, the points where 17 and 31 sectors
    // stop fitting, and quotients that are an exact multiple of 1024, where the head
    // estimate equals the quotient's need and the search must move on.
    initial begin
        queue_disk(32'd0, PH_FREE, 1'b0);
        queue_disk(32'd1, PH_FREE, 1'b0);
        queue_disk(32'd16, PH_FREE, 1'b0);
        queue_disk(32'd17, PH_FREE, 1'b0);
        queue_disk(32'd69631, PH_FREE, 1'b0);            // quotient 4095
        queue_disk(32'd69632, PH_FREE, 1'b0);            // quotient 4096
        queue_disk(32'd69649, PH_FREE, 1'b0);            // quotient 4097
        queue_disk(32'd87040, PH_FREE, 1'b0);            // quotient 5120
        queue_disk(32'd278527, PH_FREE, 1'b0);
        queue_disk(32'd278528, PH_FREE, 1'b0);
        queue_disk(32'd507903, PH_FREE, 1'b0);
        queue_disk(32'd507904, PH_FREE, 1'b0);
        queue_disk(32'd1032192, PH_FREE, 1'b0);          // 16384 tracks of 63
        queue_disk(SECTORS_WIDE - 32'd1, PH_FREE, 1'b0);
        queue_disk(SECTORS_WIDE, PH_FREE, 1'b0);
        queue_disk(SECTORS_CLAMP - 32'd1, PH_FREE, 1'b0);
        queue_disk(SECTORS_CLAMP, PH_FREE, 1'b0);
        queue_disk(SECTORS_CLAMP + 32'd1, PH_FREE, 1'b0);
        queue_disk(32'hFFFF_FFFF, PH_FREE, 1'b0);
        queue_disk(32'h8000_0000, PH_FREE, 1'b0);
        queue_disk(32'h5555_5555, PH_FREE, 1'b0);
        queue_disk(32'hAAAA_AAAA, PH_FREE, 1'b0);
        queue_disk(32'h00AA_AAAA, PH_FREE, 1'b0);
        queue_disk(32'h0155_5555, PH_FREE, 1'b0);

        // The random part cycles through the pressure phases in blocks. Now and
        // then the sender waits for every outstanding result before it goes on.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            queue_disk(random_count(), (n / PHASE_LEN) % 4, (n % 500) == 0);
        end

        wait (rst_done);
        while (pending_disks.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (expected_geom.size() != 0) begin
            @(posedge i_clk);
        end
        // The tail wait catches any stray result that the block might still give.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && expected_geom.size() == 0) begin
            $display("vhd_chs_geometry: match");
        end else begin
            $display("vhd_chs_geometry: mismatch");
        end
        $finish;
    end

    // Sampling at the rising edge. An accepted input transaction pushes its expected
    // geometry; an accepted result transaction is compared with the oldest one.
    always @(posedge i_clk) begin
        t_chs want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_geom.push_back(chs_from_count(i_total_sectors));
                disk_taken = 1'b1;
            end
            if (o_valid && !i_stall) begin
                if (expected_geom.size() == 0) begin
                    report_mismatch("result with nothing outstanding, cylinders",
                                    o_cylinders, 0);
                end else begin
                    want = expected_geom.pop_front();
                    if (o_cylinders !== want.cylinders) begin
                        report_mismatch("cylinders", o_cylinders, want.cylinders);
                    end
                    if (o_heads !== want.heads) begin
                        report_mismatch("heads", o_heads, want.heads);
                    end
                    if (o_sectors_per_track !== want.sectors_per_track) begin
                        report_mismatch("sectors_per_track", o_sectors_per_track,
                                        want.sectors_per_track);
                    end
                end
            end
        end
    end

    // Driver: changes the input channel on the falling edge. A transaction that was
    // not taken at the last rising edge is held unchanged; otherwise the next one is
    // offered, unless the phase calls for a gap or the item waits for the pipeline
    // to drain.
    always @(negedge i_clk) begin
        t_disk_item item;
        if (!rst_done) begin
            i_valid <= 1'b0;
        end else if (i_valid && !disk_taken) begin
            i_valid <= 1'b1;
        end else if (pending_disks.size() == 0) begin
            i_valid <= 1'b0;
        end else if (pending_disks[0].drain && expected_geom.size() != 0) begin
            i_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < send_gap_pct(pending_disks[0].phase)) begin
            cur_phase = pending_disks[0].phase;
            i_valid <= 1'b0;
        end else begin
            item = pending_disks.pop_front();
            cur_phase = item.phase;
            i_valid <= 1'b1;
            i_total_sectors <= item.count;
        end
        disk_taken = 1'b0;
    end

    // Receiver: stalls the result channel at random on the falling edge, as the
    // current phase asks.
    always @(negedge i_clk) begin
        if (!rst_done) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_gap_pct(cur_phase));
        end
    end

    // Watchdog: the run ends as failed if nothing is accepted on either channel for
    // too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("vhd_chs_geometry: mismatch");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule
